FILE: sv/blpg_pkg.sv
// Package for the line pixel generator: widths, reset values and item codes.
// Shared by the interfaces, the front end, the back end and the top level; depends on nothing.
`default_nettype none

package blpg_pkg;

  // Default geometry of the framebuffer
  localparam int DEF_COORD_BITS = 10;
  localparam int DEF_ADDR_BITS  = 20;

  // Fixed field widths
  localparam int COLOR_W     = 16;
  localparam int PITCH_W     = 11;
  localparam int PITCH_RESET = 240;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Item kinds carried on the func field
  typedef enum logic [0:0] {
    FUNC_LINE = 1'b0,
    FUNC_TICK = 1'b1
  } func_t;

  // Width of one queue entry: kind, four addresses/increments, two gains,
  // error seed and color
  function automatic int entry_width(input int coord_bits, input int addr_bits);
    return 1 + 4 * addr_bits + 2 * (coord_bits + 1) + (coord_bits + 2) + COLOR_W;
  endfunction

endpackage

`default_nettype wire

FILE: sv/blpg_if.sv
// Channel interfaces of the line pixel generator: line/tick input, pixel
// output and row pitch configuration. Depends on blpg_pkg.
`default_nettype none

interface blpg_in_if #(
  parameter int COORD_BITS = blpg_pkg::DEF_COORD_BITS
);
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [COORD_BITS-1:0]            x_start;
  logic [COORD_BITS-1:0]            y_start;
  logic [COORD_BITS-1:0]            x_end;
  logic [COORD_BITS-1:0]            y_end;
  logic [blpg_pkg::COLOR_W-1:0]     line_color;

  modport source (output valid, func, x_start, y_start, x_end, y_end, line_color,
                  input ready);
  modport sink   (input valid, func, x_start, y_start, x_end, y_end, line_color,
                  output ready);
endinterface

interface blpg_out_if #(
  parameter int ADDR_BITS = blpg_pkg::DEF_ADDR_BITS
);
  logic                             valid;
  logic                             ready;
  logic [ADDR_BITS-1:0]             pixel_address;
  logic [blpg_pkg::COLOR_W-1:0]     pixel_color;
  logic                             last;

  modport source (output valid, pixel_address, pixel_color, last, input ready);
  modport sink   (input valid, pixel_address, pixel_color, last, output ready);
endinterface

interface blpg_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [blpg_pkg::PITCH_W-1:0]     row_pitch;

  modport source (output valid, row_pitch, input ready);
  modport sink   (input valid, row_pitch, output ready);
endinterface

`default_nettype wire

FILE: sv/blpg_front.sv
// Front end: holds the row pitch register, accepts line and tick items and
// turns each into a queue entry (addresses, increments, error terms).
// Depends on blpg_pkg and blpg_if.
`default_nettype none

module blpg_front #(
  parameter int COORD_BITS = blpg_pkg::DEF_COORD_BITS,
  parameter int ADDR_BITS  = blpg_pkg::DEF_ADDR_BITS,
  localparam int ENTRY_W   = blpg_pkg::entry_width(COORD_BITS, ADDR_BITS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  blpg_in_if.sink                 in_ch,
  blpg_cfg_if.sink                cfg_ch,
  output logic                    push,
  output logic [ENTRY_W-1:0]      push_data,
  input  wire logic               q_full
);

  localparam int GAIN_W = COORD_BITS + 1;
  localparam int ERR_W  = COORD_BITS + 2;
  localparam int PROD_W = COORD_BITS + blpg_pkg::PITCH_W + 1;
  localparam int SUM_W  = (PROD_W > ADDR_BITS) ? PROD_W : ADDR_BITS;

  typedef struct packed {
    blpg_pkg::func_t                kind;
    logic [ADDR_BITS-1:0]           start_addr;
    logic [ADDR_BITS-1:0]           end_addr;
    logic [ADDR_BITS-1:0]           step_inc;
    logic [ADDR_BITS-1:0]           corr_inc;
    logic [GAIN_W-1:0]              minor_gain;
    logic [GAIN_W-1:0]              major_gain;
    logic signed [ERR_W-1:0]        err_init;
    logic [blpg_pkg::COLOR_W-1:0]   color;
  } entry_t;

  logic [blpg_pkg::PITCH_W-1:0] row_pitch_r;
  logic [blpg_pkg::PITCH_W-1:0] row_pitch_nxt;

  logic                  x_fwd, y_fwd;
  logic [COORD_BITS-1:0] dx, dy;
  logic [ADDR_BITS-1:0]  pitch_ext, xi, yi;
  logic [SUM_W-1:0]      start_sum, end_sum;
  entry_t                entry;

  // Configuration register, always ready
  assign cfg_ch.ready  = 1'b1;
  assign row_pitch_nxt = (cfg_ch.valid) ? cfg_ch.row_pitch : row_pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pitch_r <= blpg_pkg::PITCH_W'(blpg_pkg::PITCH_RESET);
    end else begin
      row_pitch_r <= row_pitch_nxt;
    end
  end

  // Direction and span on each axis
  assign x_fwd = (in_ch.x_end > in_ch.x_start);
  assign y_fwd = (in_ch.y_end > in_ch.y_start);
  assign dx    = x_fwd ? (in_ch.x_end - in_ch.x_start) : (in_ch.x_start - in_ch.x_end);
  assign dy    = y_fwd ? (in_ch.y_end - in_ch.y_start) : (in_ch.y_start - in_ch.y_end);

  // Signed address steps, kept modulo the address width
  assign pitch_ext = ADDR_BITS'(row_pitch_r);
  assign xi        = x_fwd ? ADDR_BITS'(1) : '1;
  assign yi        = y_fwd ? pitch_ext : (ADDR_BITS'(0) - pitch_ext);

  // Linear addresses: x + y * pitch, one multiplier per endpoint
  assign start_sum = SUM_W'(in_ch.y_start) * SUM_W'(row_pitch_r) + SUM_W'(in_ch.x_start);
  assign end_sum   = SUM_W'(in_ch.y_end) * SUM_W'(row_pitch_r) + SUM_W'(in_ch.x_end);

  // Classify the line and build the entry
  always_comb begin
    entry            = '0;
    entry.kind       = (in_ch.func == blpg_pkg::FUNC_TICK) ? blpg_pkg::FUNC_TICK
                                                           : blpg_pkg::FUNC_LINE;
    entry.start_addr = start_sum[ADDR_BITS-1:0];
    entry.end_addr   = end_sum[ADDR_BITS-1:0];
    entry.color      = in_ch.line_color;
    priority if (in_ch.x_start == in_ch.x_end) begin
      // vertical or single point
      entry.step_inc = yi;
    end else if (in_ch.y_start == in_ch.y_end) begin
      // horizontal
      entry.step_inc = xi;
    end else if (dy > dx) begin
      // y major
      entry.step_inc   = yi;
      entry.corr_inc   = xi;
      entry.minor_gain = {dx, 1'b0};
      entry.major_gain = {dy, 1'b0};
      entry.err_init   = -$signed({2'b00, dy});
    end else begin
      // x major
      entry.step_inc   = xi;
      entry.corr_inc   = yi;
      entry.minor_gain = {dy, 1'b0};
      entry.major_gain = {dx, 1'b0};
      entry.err_init   = -$signed({2'b00, dx});
    end
  end

  // Handshake into the queue
  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign push_data   = entry;

endmodule

`default_nettype wire

FILE: sv/blpg_queue.sv
// Small FIFO between front and back so each side can stall on its own.
// Generic over entry width; depends on nothing beyond its parameters.
`default_nettype none

module blpg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  not_empty,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = store_r[rd_ptr_r];

  // Pointer wrap at the depth
  assign wr_ptr_nxt = !do_push ? wr_ptr_r :
                      (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = !do_pop ? rd_ptr_r :
                      (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers apart while empty");

endmodule

`default_nettype wire

FILE: sv/blpg_back.sv
// Back end: takes entries from the queue, loads new lines and walks the
// active line one pixel per tick into a registered output stage.
// Depends on blpg_pkg and blpg_if.
`default_nettype none

module blpg_back #(
  parameter int COORD_BITS = blpg_pkg::DEF_COORD_BITS,
  parameter int ADDR_BITS  = blpg_pkg::DEF_ADDR_BITS,
  localparam int ENTRY_W   = blpg_pkg::entry_width(COORD_BITS, ADDR_BITS)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_not_empty,
  input  wire logic [ENTRY_W-1:0] q_data,
  output logic                    pop,
  blpg_out_if.source              out_ch
);

  localparam int GAIN_W = COORD_BITS + 1;
  localparam int ERR_W  = COORD_BITS + 2;

  typedef struct packed {
    blpg_pkg::func_t                kind;
    logic [ADDR_BITS-1:0]           start_addr;
    logic [ADDR_BITS-1:0]           end_addr;
    logic [ADDR_BITS-1:0]           step_inc;
    logic [ADDR_BITS-1:0]           corr_inc;
    logic [GAIN_W-1:0]              minor_gain;
    logic [GAIN_W-1:0]              major_gain;
    logic signed [ERR_W-1:0]        err_init;
    logic [blpg_pkg::COLOR_W-1:0]   color;
  } entry_t;

  entry_t entry;

  // Line state
  logic                         active_r, active_nxt;
  logic [ADDR_BITS-1:0]         cur_r, cur_nxt;
  logic [ADDR_BITS-1:0]         end_r;
  logic signed [ERR_W-1:0]      err_r, err_nxt;
  logic [GAIN_W-1:0]            minor_r, major_r;
  logic [ADDR_BITS-1:0]         step_r, corr_r;
  logic [blpg_pkg::COLOR_W-1:0] color_r;

  // Output stage
  logic                         out_valid_r, out_valid_nxt;
  logic [ADDR_BITS-1:0]         out_addr_r;
  logic [blpg_pkg::COLOR_W-1:0] out_color_r;
  logic                         out_last_r;

  logic                    is_line, is_tick, out_free, load, emit, at_end, err_pos;
  logic signed [ERR_W-1:0] err_sum;

  assign entry    = entry_t'(q_data);
  assign is_line  = q_not_empty && (entry.kind == blpg_pkg::FUNC_LINE);
  assign is_tick  = q_not_empty && (entry.kind == blpg_pkg::FUNC_TICK);
  assign out_free = !out_valid_r || out_ch.ready;

  // Lines load at once; ticks wait for room only when they make a pixel
  assign load = is_line;
  assign emit = is_tick && active_r && out_free;
  assign pop  = load || (is_tick && (!active_r || out_free));

  // One Bresenham step
  assign at_end  = (cur_r == end_r);
  assign err_sum = err_r + $signed({1'b0, minor_r});
  assign err_pos = (err_sum > 0);

  always_comb begin
    active_nxt = active_r;
    cur_nxt    = cur_r;
    err_nxt    = err_r;
    if (load) begin
      active_nxt = 1'b1;
      cur_nxt    = entry.start_addr;
      err_nxt    = entry.err_init;
    end else if (emit) begin
      if (at_end) begin
        active_nxt = 1'b0;
      end else begin
        cur_nxt = cur_r + step_r + (err_pos ? corr_r : '0);
        err_nxt = err_pos ? (err_sum - $signed({1'b0, major_r})) : err_sum;
      end
    end
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Walk and output payload
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    err_r <= err_nxt;
    if (load) begin
      end_r   <= entry.end_addr;
      minor_r <= entry.minor_gain;
      major_r <= entry.major_gain;
      step_r  <= entry.step_inc;
      corr_r  <= entry.corr_inc;
      color_r <= entry.color;
    end
    if (emit) begin
      out_addr_r  <= cur_r;
      out_color_r <= color_r;
      out_last_r  <= at_end;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.pixel_address = out_addr_r;
  assign out_ch.pixel_color   = out_color_r;
  assign out_ch.last          = out_last_r;

  a_err_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (err_r <= 0))
    else $error("error term positive between steps");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && at_end) |=> (!active_r && out_valid_r && out_last_r))
    else $error("end pixel did not close the line");

  a_load_active: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> active_r)
    else $error("line load did not start the walk");

  a_rise_from_active: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(active_r))
    else $error("pixel issued while idle");

endmodule

`default_nettype wire

FILE: sv/bresenham_line_pixel_generator.sv
// Top level of the line pixel generator: front end, entry queue, back end.
// Depends on blpg_pkg, blpg_if, blpg_front, blpg_queue and blpg_back.
//
// A line item (func 0) sets up a line between two endpoints: the front end
// forms both linear addresses (x + y * row_pitch, one multiplier per
// endpoint) and the step terms and queues them. Each tick item (func 1) then
// yields one pixel write while a line is active, the end pixel flagged by
// last; ticks while idle yield nothing, and a new line drops the old one.
// Sustained rate is one item per clock while the output does not stall, set
// by the back end's address add and error update. A pixel reaches the output
// once its tick is written into the queue and then moved by the back end into
// the output register; output stalls can hold it in the queue. A four-entry
// queue lets input keep flowing while the output stalls. row_pitch resets to
// 240 and is written through the configuration channel, which is always ready.
`default_nettype none

module bresenham_line_pixel_generator #(
  parameter int COORD_BITS = blpg_pkg::DEF_COORD_BITS,
  parameter int ADDR_BITS  = blpg_pkg::DEF_ADDR_BITS
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  blpg_in_if.sink     in_ch,
  blpg_out_if.source  out_ch,
  blpg_cfg_if.sink    cfg_ch
);

  localparam int ENTRY_W = blpg_pkg::entry_width(COORD_BITS, ADDR_BITS);

  logic               push, q_full, pop, q_not_empty;
  logic [ENTRY_W-1:0] push_data, pop_data;

  blpg_front #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  blpg_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (blpg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .pop_data  (pop_data)
  );

  blpg_back #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_data      (pop_data),
    .pop         (pop),
    .out_ch      (out_ch)
  );

endmodule

`default_nettype wire

FILE: sim/tb_bresenham_line_pixel_generator.sv
// Self-checking testbench for the line pixel generator: random line and tick
// items, random stalls on both channels, row pitch changes between phases.
// Depends on blpg_pkg, blpg_if and the bresenham_line_pixel_generator RTL.

module tb_bresenham_line_pixel_generator;

  localparam int CW             = blpg_pkg::DEF_COORD_BITS;
  localparam int AW             = blpg_pkg::DEF_ADDR_BITS;
  localparam int COORD_MAX      = (1 << CW) - 1;
  localparam int ITEM_TARGET    = 1850;
  localparam int DIRECTED_ITEMS = 24;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = (ITEM_TARGET - DIRECTED_ITEMS) / PHASES;
  localparam int HOLD_CYCLES    = 250;
  localparam int SETTLE_CYCLES  = 10;
  localparam int QUIET_LIMIT    = 4000;

  typedef struct packed {
    blpg_pkg::func_t                func;
    logic [CW-1:0]                  x_start;
    logic [CW-1:0]                  y_start;
    logic [CW-1:0]                  x_end;
    logic [CW-1:0]                  y_end;
    logic [blpg_pkg::COLOR_W-1:0]   line_color;
  } line_item_t;

  typedef struct packed {
    logic [AW-1:0]                  address;
    logic [blpg_pkg::COLOR_W-1:0]   color;
    logic                           last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n;

  blpg_in_if  #(.COORD_BITS(CW)) in_ch();
  blpg_out_if #(.ADDR_BITS(AW))  out_ch();
  blpg_cfg_if                    cfg_ch();

  bresenham_line_pixel_generator #(
    .COORD_BITS (CW),
    .ADDR_BITS  (AW)
  ) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #4 clk = ~clk;

  // Items waiting to be driven, pixels waiting to come out
  line_item_t item_queue[$];
  pixel_t     pending_pixels[$];
  int         errors = 0;

  // Idle control: per-item wait drawn from 0..max, long hold on request
  int in_gap_max    = 6;
  int out_gap_max   = 6;
  int hold_request  = 0;
  int hold_served   = 0;

  // Line walker state mirrored from the block
  logic [blpg_pkg::PITCH_W-1:0] pitch_q = blpg_pkg::PITCH_W'(blpg_pkg::PITCH_RESET);
  bit                           walk_active = 1'b0;
  logic [AW-1:0]                walk_addr   = '0;
  logic [AW-1:0]                walk_end    = '0;
  logic [blpg_pkg::COLOR_W-1:0] walk_color  = '0;
  int                           walk_err    = 0;
  int                           walk_minor  = 0;
  int                           walk_major  = 0;
  int                           walk_step   = 0;
  int                           walk_corr   = 0;

  function automatic logic [AW-1:0] linear_address(input int x, input int y);
    return AW'(x + y * int'(pitch_q));
  endfunction

  // Apply one accepted item to the walker; a tick while active yields a pixel
  function automatic void predict_pixel(input line_item_t it);
    int     xs, ys, xe, ye, dx, dy, xi, yi;
    pixel_t px;
    if (it.func == blpg_pkg::FUNC_LINE) begin
      xs = it.x_start;
      ys = it.y_start;
      xe = it.x_end;
      ye = it.y_end;
      xi = (xe > xs) ? 1 : -1;
      yi = (ye > ys) ? int'(pitch_q) : -int'(pitch_q);
      dx = (xe > xs) ? xe - xs : xs - xe;
      dy = (ye > ys) ? ye - ys : ys - ye;
      if (xs == xe || ys == ye) begin
        // straight line or single point: never takes the correction step
        walk_step  = (xs == xe) ? yi : xi;
        walk_corr  = 0;
        walk_minor = 0;
        walk_major = 0;
        walk_err   = 0;
      end else if (dy > dx) begin
        walk_step  = yi;
        walk_corr  = xi;
        walk_minor = 2 * dx;
        walk_major = 2 * dy;
        walk_err   = -dy;
      end else begin
        walk_step  = xi;
        walk_corr  = yi;
        walk_minor = 2 * dy;
        walk_major = 2 * dx;
        walk_err   = -dx;
      end
      walk_addr   = linear_address(xs, ys);
      walk_end    = linear_address(xe, ye);
      walk_color  = it.line_color;
      walk_active = 1'b1;
    end else if (walk_active) begin
      px.address = walk_addr;
      px.color   = walk_color;
      px.last    = (walk_addr == walk_end);
      pending_pixels.push_back(px);
      if (px.last) begin
        walk_active = 1'b0;
      end else begin
        walk_err  = walk_err + walk_minor;
        walk_addr = AW'(int'(walk_addr) + walk_step);
        if (walk_err > 0) begin
          walk_addr = AW'(int'(walk_addr) + walk_corr);
          walk_err  = walk_err - walk_major;
        end
      end
    end
  endfunction

  // Input driver: holds one item until accepted, then waits its drawn gap
  line_item_t cur_item;
  int         in_gap_left = 0;

  always @(posedge clk) begin : drive_items
    bit take;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap_left = 0;
    end else begin
      take = in_ch.valid && in_ch.ready;
      if (take) begin
        predict_pixel(cur_item);
        in_gap_left = $urandom_range(0, in_gap_max);
      end
      if (!in_ch.valid || take) begin
        if (in_gap_left > 0) begin
          in_gap_left--;
          in_ch.valid <= 1'b0;
        end else if (item_queue.size() > 0) begin
          cur_item = item_queue.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.func       <= cur_item.func;
          in_ch.x_start    <= cur_item.x_start;
          in_ch.y_start    <= cur_item.y_start;
          in_ch.x_end      <= cur_item.x_end;
          in_ch.y_end      <= cur_item.y_end;
          in_ch.line_color <= cur_item.line_color;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Pixel monitor: compares against the oldest expected pixel, stalls at random
  int out_wait = 0;

  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_pixels.size() == 0) begin
          $error("unexpected pixel item: pixel_address %0h", out_ch.pixel_address);
          errors++;
        end else begin
          want = pending_pixels.pop_front();
          if (out_ch.pixel_address !== want.address) begin
            $error("pixel_address: expected %0h, got %0h", want.address,
                   out_ch.pixel_address);
            errors++;
          end
          if (out_ch.pixel_color !== want.color) begin
            $error("pixel_color: expected %0h, got %0h", want.color, out_ch.pixel_color);
            errors++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            errors++;
          end
        end
        out_wait = $urandom_range(0, out_gap_max);
      end
      if (hold_served != hold_request) begin
        // long hold-off so the block backs up into its input
        hold_served = hold_request;
        out_wait = HOLD_CYCLES;
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no channel moves an item for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("bresenham_line_pixel_generator: mismatch");
    $finish;
  end

  task automatic push_line(input int xs, input int ys, input int xe, input int ye,
                           input int color);
    line_item_t it;
    it.func       = blpg_pkg::FUNC_LINE;
    it.x_start    = CW'(xs);
    it.y_start    = CW'(ys);
    it.x_end      = CW'(xe);
    it.y_end      = CW'(ye);
    it.line_color = blpg_pkg::COLOR_W'(color);
    item_queue.push_back(it);
  endtask

  // Ticks carry random junk in the unused fields
  task automatic push_ticks(input int count);
    line_item_t it;
    for (int i = 0; i < count; i++) begin
      it.func       = blpg_pkg::FUNC_TICK;
      it.x_start    = CW'($urandom);
      it.y_start    = CW'($urandom);
      it.x_end      = CW'($urandom);
      it.y_end      = CW'($urandom);
      it.line_color = blpg_pkg::COLOR_W'($urandom);
      item_queue.push_back(it);
    end
  endtask

  function automatic int jitter_coord(input int c, input int span);
    int v;
    v = c + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // Mostly complete lines of random shape; some cut short, some after stray ticks
  task automatic queue_random_lines(input int budget);
    int counted, sel, span, xs, ys, xe, ye, need, ticks, stray;
    counted = 0;
    while (counted < budget) begin
      sel  = $urandom_range(0, 99);
      span = (sel < 1) ? 300 : ((sel < 15) ? 40 : 8);
      xs   = $urandom_range(0, COORD_MAX);
      ys   = $urandom_range(0, COORD_MAX);
      xe   = jitter_coord(xs, span);
      ye   = jitter_coord(ys, span);
      sel  = $urandom_range(0, 99);
      if (sel < 12) begin
        ye = ys;
      end else if (sel < 24) begin
        xe = xs;
      end else if (sel < 28) begin
        xe = xs;
        ye = ys;
      end
      need = (((xe > xs) ? xe - xs : xs - xe) > ((ye > ys) ? ye - ys : ys - ye)) ?
             ((xe > xs) ? xe - xs : xs - xe) + 1 : ((ye > ys) ? ye - ys : ys - ye) + 1;
      stray = 0;
      sel = $urandom_range(0, 99);
      if (sel < 80) begin
        ticks = need + $urandom_range(0, 2);
      end else if (sel < 95) begin
        // next line item drops this one mid-walk
        ticks = $urandom_range(0, need - 1);
      end else begin
        stray = $urandom_range(1, 3);
        push_ticks(stray);
        ticks = need;
      end
      push_line(xs, ys, xe, ye, $urandom_range(0, 16'hFFFF));
      push_ticks(ticks);
      counted += 1 + ticks + stray;
    end
  endtask

  task automatic wait_drained();
    while (item_queue.size() != 0 || in_ch.valid || pending_pixels.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pitch(input int pitch);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.row_pitch <= blpg_pkg::PITCH_W'(pitch);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    pitch_q = blpg_pkg::PITCH_W'(pitch);
  endtask

  initial begin : stimulus
    int pitch_plan[PHASES];
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.func       = blpg_pkg::FUNC_LINE;
    in_ch.x_start    = '0;
    in_ch.y_start    = '0;
    in_ch.x_end      = '0;
    in_ch.y_end      = '0;
    in_ch.line_color = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.row_pitch = '0;
    pitch_plan = '{1024, 1, 2047, 0, 0, 0};
    pitch_plan[4] = $urandom_range(1, 1024);
    pitch_plan[5] = $urandom_range(1, 1024);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines at the reset pitch
    push_ticks(1);                                    // tick while idle
    push_line(0, 0, 0, 0, 16'hFFFF);                  // single point, then idle tick
    push_ticks(2);
    push_line(COORD_MAX, 0, 0, COORD_MAX, 16'h8001);  // long diagonal, dropped early
    push_ticks(2);
    push_line(5, 3, 1, 3, 16'hA5A5);                  // horizontal, right to left
    push_ticks(5);
    push_line(7, 2, 7, 5, 16'h5A5A);                  // vertical, downward
    push_ticks(4);
    push_line(0, COORD_MAX, 2, COORD_MAX - 4, 16'h0000);  // steep, upward
    push_ticks(5);

    // Phases at other pitches; phase 1 holds off the output, phase 4 never idles
    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_pitch(pitch_plan[p]);
      in_gap_max  = (p == 1 || p == 4) ? 0 : 6;
      out_gap_max = (p == 4) ? 0 : 6;
      if (p == 1) hold_request++;
      queue_random_lines(PHASE_ITEMS);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("bresenham_line_pixel_generator: match");
    end else begin
      $display("bresenham_line_pixel_generator: mismatch");
    end
    $finish;
  end

endmodule
